FILE: hdl/assert_macros.svh
// Assertion macros for the set's top level, which checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is asserted.
`define SUI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define SUI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/sui_pkg.sv
// Types and codes of the sorted unique index set.
package sui_pkg;

  localparam int KEY_W = 32;
  localparam int FUNC_W = 3;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

  // Update command broadcast to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             clr;
    logic [KEY_W-1:0] key;
  } sui_ctl_t;

endpackage

FILE: hdl/sorted_unique_index_set.sv
// Top level of the sorted unique index set: a row of compare-and-shift cells.
//
// Holds an ascending list of distinct 32-bit keys, up to DEPTH of them, one key
// per cell. A transaction is accepted on a rising edge with start high and busy
// low; in_func selects add, remove, find, read at position or clear.
// The operation is registered at acceptance, busy stays high for one cycle while
// every cell compares its key with the transaction key and the row shifts one
// place right (insert) or left (remove) at the lower bound, all in that cycle.
// The result appears on the out_ ports in the cycle after the busy cycle, stays for
// exactly one cycle with out_valid high and is taken at the edge that ends it;
// it cannot be held off by the receiver.
// A new transaction can be accepted at the edge that ends the result cycle but not
// while busy is high, since the compare, lower bound search and shift of the cell
// row fill the busy cycle.
// Reset empties the list and clears busy and out_valid; stored keys are not
// cleared, since only cells below the count are ever read.
module sorted_unique_index_set
  import sui_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [7:0]          in_position,
  output logic                out_valid,
  output logic                out_found,
  output logic [7:0]          out_found_position,
  output logic [KEY_W-1:0]    out_read_key,
  output logic [8:0]          out_entry_count,
  output logic                out_count_changed,
  output logic [STATUS_W-1:0] out_status
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [7:0]        position;
  } op_t;

  op_t              op_r;
  logic             op_valid_r;
  logic [CW-1:0]    count_r, count_nxt;

  logic             out_valid_r;
  logic             out_found_r, out_found_nxt;
  logic [7:0]       out_fpos_r, out_fpos_nxt;
  logic [KEY_W-1:0] out_rkey_r, out_rkey_nxt;
  logic [8:0]       out_count_r;
  logic             out_changed_r, out_changed_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [KEY_W-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0] cell_valid, cell_lt, cell_eq, cell_bnd;

  sui_ctl_t         ctl;
  logic             hit, full, read_ok;
  logic [IW-1:0]    lb_pos;
  logic [KEY_W-1:0] sel_key;

  // The cells deliver a thermometer of "key below" flags; the lower bound is at most
  // one cell, at its edge, so hit and its position come from one-hot reduction.
  always_comb begin
    hit = 1'b0;
    lb_pos = '0;
    sel_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit = hit | (cell_bnd[i] & cell_eq[i]);
      if (cell_bnd[i]) begin
        lb_pos = lb_pos | IW'(i);
      end
      if (32'(op_r.position) == 32'(i)) begin
        sel_key = sel_key | cell_key[i];
      end
    end
  end

  assign full = (count_r == CW'(DEPTH));
  assign read_ok = (32'(op_r.position) < 32'(count_r));

  always_comb begin
    ctl = '0;
    ctl.key = op_r.key;
    count_nxt = count_r;
    out_found_nxt = 1'b0;
    out_fpos_nxt = '0;
    out_rkey_nxt = '0;
    out_changed_nxt = 1'b0;
    out_status_nxt = STATUS_OK;
    unique case (op_r.func)
      FUNC_ADD: begin
        if (hit) begin
          out_found_nxt = 1'b1;
          out_fpos_nxt = 8'(lb_pos);
        end else if (full) begin
          out_status_nxt = STATUS_FULL;
        end else begin
          ctl.ins = op_valid_r;
          count_nxt = count_r + CW'(1);
          out_found_nxt = 1'b1;
          out_fpos_nxt = 8'(lb_pos);
          out_changed_nxt = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (hit) begin
          ctl.del = op_valid_r;
          count_nxt = count_r - CW'(1);
          out_found_nxt = 1'b1;
          out_fpos_nxt = 8'(lb_pos);
          out_changed_nxt = 1'b1;
        end else begin
          out_status_nxt = STATUS_ABSENT;
        end
      end
      FUNC_FIND: begin
        if (hit) begin
          out_found_nxt = 1'b1;
          out_fpos_nxt = 8'(lb_pos);
        end else begin
          out_status_nxt = STATUS_ABSENT;
        end
      end
      FUNC_READ: begin
        if (read_ok) begin
          out_found_nxt = 1'b1;
          out_fpos_nxt = op_r.position;
          out_rkey_nxt = sel_key;
        end else begin
          out_status_nxt = STATUS_ABSENT;
        end
      end
      FUNC_CLEAR: begin
        ctl.clr = op_valid_r;
        count_nxt = '0;
        out_changed_nxt = (count_r != '0);
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0] lk, rk;
    logic             lv, llt, rv;
    if (g == 0) begin : g_first
      assign lk = '0;
      assign lv = 1'b0;
      assign llt = 1'b1;
    end else begin : g_mid
      assign lk = cell_key[g-1];
      assign lv = cell_valid[g-1];
      assign llt = cell_lt[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign rk = '0;
      assign rv = 1'b0;
    end else begin : g_next
      assign rk = cell_key[g+1];
      assign rv = cell_valid[g+1];
    end
    sui_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .lookup_key  (op_r.key),
      .ctl         (ctl),
      .left_key    (lk),
      .left_valid  (lv),
      .left_lt     (llt),
      .right_key   (rk),
      .right_valid (rv),
      .key         (cell_key[g]),
      .valid       (cell_valid[g]),
      .lt          (cell_lt[g]),
      .eq          (cell_eq[g]),
      .boundary    (cell_bnd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      count_r <= '0;
    end else begin
      op_valid_r <= start && !op_valid_r;
      out_valid_r <= op_valid_r;
      if (op_valid_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !op_valid_r) begin
      op_r.func <= in_func;
      op_r.key <= in_key;
      op_r.position <= in_position;
    end
    if (op_valid_r) begin
      out_found_r <= out_found_nxt;
      out_fpos_r <= out_fpos_nxt;
      out_rkey_r <= out_rkey_nxt;
      out_count_r <= 9'(count_nxt);
      out_changed_r <= out_changed_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign busy = op_valid_r;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_found_position = out_fpos_r;
  assign out_read_key = out_rkey_r;
  assign out_entry_count = out_count_r;
  assign out_count_changed = out_changed_r;
  assign out_status = out_status_r;

`include "assert_macros.svh"

  `SUI_ASSERT(a_strobe_after_busy, out_valid |-> $past(op_valid_r), "result without transaction")
  `SUI_ASSERT(a_count_bound, 32'(count_r) <= 32'(DEPTH), "count beyond depth")
  `SUI_ASSERT(a_first_cell_count, cell_valid[0] == (count_r != '0), "cell row and count disagree")
  `SUI_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !busy && !out_valid, "not idle after reset")

endmodule

FILE: hdl/sui_cell.sv
// One compare-and-shift cell holding a single key of the sorted row.
module sui_cell
  import sui_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] lookup_key,
  input  sui_ctl_t         ctl,
  input  logic [KEY_W-1:0] left_key,
  input  logic             left_valid,
  input  logic             left_lt,
  input  logic [KEY_W-1:0] right_key,
  input  logic             right_valid,
  output logic [KEY_W-1:0] key,
  output logic             valid,
  output logic             lt,
  output logic             eq,
  output logic             boundary
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic             valid_r, valid_nxt;

  assign lt = valid_r && (key_r < lookup_key);
  assign eq = valid_r && (key_r == lookup_key);
  // The first cell whose key is not below the lookup key: the lower bound.
  assign boundary = !lt && left_lt;

  always_comb begin
    key_nxt = key_r;
    valid_nxt = valid_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins && !lt) begin
      if (boundary) begin
        key_nxt = ctl.key;
        valid_nxt = 1'b1;
      end else begin
        key_nxt = left_key;
        valid_nxt = left_valid;
      end
    end else if (ctl.del && !lt) begin
      key_nxt = right_key;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key = key_r;
  assign valid = valid_r;

endmodule
